FILE: hdl/ffa_pkg.sv
// Shared definitions for the first-fit free-list allocator.
// Holds sizes, status codes, the list entry type and the sequencer states.
// No dependencies.
package ffa_pkg;

   localparam int MAX_FREE  = 16;
   localparam int ADDR_BITS = 24;

   localparam int IDX_W = $clog2(MAX_FREE);
   localparam int CNT_W = $clog2(MAX_FREE + 1);
   localparam int OFF_W = ADDR_BITS;
   localparam int LEN_W = ADDR_BITS + 1;
   localparam int SUM_W = ADDR_BITS + 2;

   localparam logic [SUM_W-1:0] ADDR_LIMIT = SUM_W'(1) << ADDR_BITS;
   localparam logic [LEN_W-1:0] CAP_RESET  = LEN_W'(65536);

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OOS  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic [OFF_W-1:0] start;
      logic [LEN_W-1:0] length;
   } entry_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_A_RD,
      S_A_CHK,
      S_A_GROW,
      S_F_RD,
      S_F_CHK,
      S_F_DEC,
      S_SH_DN,
      S_SH_DNW,
      S_SH_UP,
      S_SH_UPW,
      S_DONE
   } state_type;

endpackage

FILE: hdl/first_fit_free_list_allocator_unit.sv
// First-fit free-list allocator with growth and coalescing: top level.
// Depends on ffa_pkg.
//
// The free list lives in a 16-entry synchronous memory of (offset, length)
// words, kept sorted by offset. Each request word is handled by a sequencer
// that reads the entries one at a time through the single read port: an
// allocate scans the list for the first fitting block, and each capacity
// doubling is followed by a rescan from the first entry; a free scans to its
// sorted place, then merges or inserts. Removing or inserting an entry moves
// the entries behind it one by one. A zero-size or rejected free is answered
// without a scan. An allocate may double the capacity many times, up to 24
// doublings from a pool of one. One result word is produced per request
// word; it sits in an output register, so the next request word is taken
// while it waits. After reset the S_INIT state writes the initial block into
// the memory before the first request is accepted. A write to the capacity
// register rebuilds the list as one block covering the whole new pool.
module first_fit_free_list_allocator_unit
   import ffa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [24:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // block_offset[23:0], block_size[48:24], zero
   input  logic [0:0]  req_tuser,  // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // alloc_offset[23:0], status[25:24],
                                   // grew[26], capacity[51:27], zero
);

   // Free-list memory, one read and one write per cycle.
   entry_type mem_ff [MAX_FREE];
   entry_type mem_q_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [IDX_W-1:0] mem_ra;
   entry_type        mem_wd;

   state_type state_ff, state_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [LEN_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] cap_ff, cap_in;
   entry_type        cur_ff, cur_in;
   entry_type        prev_ff, prev_in;
   logic             have_prev_ff, have_prev_in;
   logic             have_next_ff, have_next_in;
   logic             grew_ff, grew_in;
   logic [1:0]       status_ff, status_in;
   logic [OFF_W-1:0] res_off_ff, res_off_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [55:0]      rsp_data_ff, rsp_data_in;

   logic             accept;
   logic [OFF_W-1:0] req_off;
   logic [LEN_W-1:0] req_size;
   logic [LEN_W-1:0] csr_cap;
   logic [SUM_W-1:0] req_end;
   logic [SUM_W-1:0] free_end;
   logic [SUM_W-1:0] cap2;
   logic             cur_ends_at_cap;
   logic             join_prev, join_next;

   assign req_off    = req_tdata[23:0];
   assign req_size   = req_tdata[48:24];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A zero capacity is taken as one; anything past the address range is clamped.
   always_comb begin
      csr_cap = csr_wdata;
      if (csr_wdata == '0) begin
         csr_cap = LEN_W'(1);
      end else if ({1'b0, csr_wdata} > ADDR_LIMIT) begin
         csr_cap = ADDR_LIMIT[LEN_W-1:0];
      end
   end

   assign req_end  = {2'b00, req_off} + {1'b0, req_size};
   assign free_end = {2'b00, off_ff} + {1'b0, size_ff};
   assign cap2     = {cap_ff, 1'b0};
   assign cur_ends_at_cap =
      ({2'b00, cur_ff.start} + {1'b0, cur_ff.length}) == {1'b0, cap_ff};
   assign join_prev = have_prev_ff &&
      (({2'b00, prev_ff.start} + {1'b0, prev_ff.length}) == {2'b00, off_ff});
   assign join_next = have_next_ff && ({2'b00, cur_ff.start} == free_end);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem_ff[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= CNT_W'(1);
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      off_ff       <= off_in;
      size_ff      <= size_in;
      idx_ff       <= idx_in;
      k_ff         <= k_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      have_prev_ff <= have_prev_in;
      have_next_ff <= have_next_in;
      grew_ff      <= grew_in;
      status_ff    <= status_in;
      res_off_ff   <= res_off_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      off_in       = off_ff;
      size_in      = size_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      cap_in       = cap_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      have_next_in = have_next_ff;
      grew_in      = grew_ff;
      status_in    = status_ff;
      res_off_in   = res_off_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = '0;
      mem_ra       = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         S_INIT: begin
            mem_we   = 1'b1;
            mem_wd   = '{start: '0, length: cap_ff};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               off_in       = req_off;
               size_in      = req_size;
               idx_in       = '0;
               grew_in      = 1'b0;
               res_off_in   = '0;
               status_in    = ST_OK;
               have_prev_in = 1'b0;
               have_next_in = 1'b0;
               if (req_tuser[0] == OP_ALLOC) begin
                  state_in = (cnt_ff == '0) ? S_A_GROW : S_A_RD;
               end else if (req_size == '0) begin
                  state_in = S_DONE;
               end else if (req_end > {1'b0, cap_ff}) begin
                  status_in = ST_OOS;
                  state_in  = S_DONE;
               end else begin
                  state_in = (cnt_ff == '0) ? S_F_DEC : S_F_RD;
               end
            end
         end
         S_A_RD: begin
            state_in = S_A_CHK;
         end
         S_A_CHK: begin
            cur_in = mem_q_ff;
            if (mem_q_ff.length >= size_ff) begin
               res_off_in = mem_q_ff.start;
               if (mem_q_ff.length == size_ff) begin
                  // Exact fit: close the gap behind this entry.
                  k_in     = idx_ff;
                  state_in = S_SH_DN;
               end else begin
                  mem_we   = 1'b1;
                  mem_wa   = idx_ff[IDX_W-1:0];
                  mem_wd.start  = mem_q_ff.start + size_ff[OFF_W-1:0];
                  mem_wd.length = mem_q_ff.length - size_ff;
                  state_in = S_DONE;
               end
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = (idx_ff + CNT_W'(1) == cnt_ff) ? S_A_GROW : S_A_RD;
            end
         end
         S_A_GROW: begin
            // cur_ff holds the last entry here whenever the list is not empty.
            idx_in = '0;
            if (cap2 > ADDR_LIMIT) begin
               status_in  = ST_OOS;
               res_off_in = '0;
               state_in   = S_DONE;
            end else if (cnt_ff != '0 && cur_ends_at_cap) begin
               mem_we   = 1'b1;
               mem_wa   = IDX_W'(cnt_ff - CNT_W'(1));
               mem_wd.start  = cur_ff.start;
               mem_wd.length = cur_ff.length + cap_ff;
               cap_in   = cap2[LEN_W-1:0];
               grew_in  = 1'b1;
               state_in = S_A_RD;
            end else if (cnt_ff >= CNT_W'(MAX_FREE)) begin
               status_in  = ST_FULL;
               res_off_in = '0;
               state_in   = S_DONE;
            end else begin
               mem_we   = 1'b1;
               mem_wa   = cnt_ff[IDX_W-1:0];
               mem_wd.start  = cap_ff[OFF_W-1:0];
               mem_wd.length = cap_ff;
               cnt_in   = cnt_ff + CNT_W'(1);
               cap_in   = cap2[LEN_W-1:0];
               grew_in  = 1'b1;
               state_in = S_A_RD;
            end
         end
         S_F_RD: begin
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            if (mem_q_ff.start <= off_ff) begin
               prev_in      = mem_q_ff;
               have_prev_in = 1'b1;
               idx_in       = idx_ff + CNT_W'(1);
               state_in = (idx_ff + CNT_W'(1) == cnt_ff) ? S_F_DEC : S_F_RD;
            end else begin
               cur_in       = mem_q_ff;
               have_next_in = 1'b1;
               state_in     = S_F_DEC;
            end
         end
         S_F_DEC: begin
            // idx_ff is the insertion point; prev is the entry before it.
            if (join_prev && join_next) begin
               mem_we   = 1'b1;
               mem_wa   = IDX_W'(idx_ff - CNT_W'(1));
               mem_wd.start  = prev_ff.start;
               mem_wd.length = prev_ff.length + size_ff + cur_ff.length;
               k_in     = idx_ff;
               state_in = S_SH_DN;
            end else if (join_prev) begin
               mem_we   = 1'b1;
               mem_wa   = IDX_W'(idx_ff - CNT_W'(1));
               mem_wd.start  = prev_ff.start;
               mem_wd.length = prev_ff.length + size_ff;
               state_in = S_DONE;
            end else if (join_next) begin
               mem_we   = 1'b1;
               mem_wa   = idx_ff[IDX_W-1:0];
               mem_wd.start  = off_ff;
               mem_wd.length = cur_ff.length + size_ff;
               state_in = S_DONE;
            end else if (cnt_ff >= CNT_W'(MAX_FREE)) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               k_in     = cnt_ff;
               state_in = S_SH_UP;
            end
         end
         S_SH_DN: begin
            if (k_ff + CNT_W'(1) < cnt_ff) begin
               mem_ra   = IDX_W'(k_ff + CNT_W'(1));
               state_in = S_SH_DNW;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_SH_DNW: begin
            mem_we   = 1'b1;
            mem_wa   = k_ff[IDX_W-1:0];
            mem_wd   = mem_q_ff;
            k_in     = k_ff + CNT_W'(1);
            state_in = S_SH_DN;
         end
         S_SH_UP: begin
            if (k_ff > idx_ff) begin
               mem_ra   = IDX_W'(k_ff - CNT_W'(1));
               state_in = S_SH_UPW;
            end else begin
               mem_we   = 1'b1;
               mem_wa   = idx_ff[IDX_W-1:0];
               mem_wd.start  = off_ff;
               mem_wd.length = size_ff;
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_SH_UPW: begin
            mem_we   = 1'b1;
            mem_wa   = k_ff[IDX_W-1:0];
            mem_wd   = mem_q_ff;
            k_in     = k_ff - CNT_W'(1);
            state_in = S_SH_UP;
         end
         S_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, cap_ff, grew_ff, status_ff, res_off_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A capacity write rebuilds the list; it must only arrive while idle, which the block does not enforce.
      if (csr_we) begin
         mem_we = 1'b1;
         mem_wa = '0;
         mem_wd = '{start: '0, length: csr_cap};
         cap_in = csr_cap;
         cnt_in = CNT_W'(1);
      end
   end

endmodule

FILE: hdl/ffa_checker.sv
// Port-level checks for the first-fit free-list allocator.
// Depends on ffa_pkg; bound to first_fit_free_list_allocator_unit below.
module ffa_checker
   import ffa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[25:24] != 2'b11)
      else $error("undefined status code");

   a_err_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[25:24] != ST_OK |-> rsp_tdata[23:0] == '0)
      else $error("nonzero offset on a failed request");

   a_grew_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[26] |-> rsp_tdata[51:27] >= 25'd2)
      else $error("growth reported with capacity below two");

endmodule

bind first_fit_free_list_allocator_unit ffa_checker u_ffa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
